// ===== sv/gtm_pkg.sv =====
package gtm_pkg;

    // Field widths.
    localparam int GEST_W   = 8;
    localparam int FINGER_W = 4;
    localparam int MOVE_W   = 16;
    localparam int DELTA_W  = 8;
    localparam int BTN_W    = 3;
    localparam int GAIN_W   = 10;

    // Configuration port.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_ACCEL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CEILING = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_BASE_RST    = 10'd100;
    localparam logic [GAIN_W-1:0] GAIN_ACCEL_RST   = 10'd0;
    localparam logic [GAIN_W-1:0] GAIN_CEILING_RST = 10'd100;

    // Gesture bits.
    localparam int GA_TAP_BIT    = 0;
    localparam int GA_HOLD_BIT   = 1;
    localparam int GB_TAP2_BIT   = 0;
    localparam int GB_SCROLL_BIT = 1;

    // Button codes.
    localparam logic [BTN_W-1:0] BTN_NONE   = 3'b000;
    localparam logic [BTN_W-1:0] BTN_LEFT   = 3'b001;
    localparam logic [BTN_W-1:0] BTN_RIGHT  = 3'b010;
    localparam logic [BTN_W-1:0] BTN_MIDDLE = 3'b100;

    localparam logic [FINGER_W-1:0] MIDDLE_MIN_FINGERS = 4'd3;

    // Saturation and scaling constants.
    localparam int SAT_MAX     = 127;
    localparam int WHEEL_SHIFT = 3;
    localparam int PCT         = 100;

    // Speed is the larger absolute motion, saturated to 15 bits.
    localparam int SPEED_W = MOVE_W - 1;

    // Acceleration divide by a constant through a rounded-up reciprocal.
    localparam int    ACCEL_DIVISOR = 1000;
    localparam int    ACC_PROD_W    = GAIN_W + SPEED_W;
    localparam int    ACC_SHIFT     = ACC_PROD_W + $clog2(ACCEL_DIVISOR) + 1;
    localparam longint ACC_RECIP    =
        ((longint'(1) <<< ACC_SHIFT) + ACCEL_DIVISOR - 1) / ACCEL_DIVISOR;
    localparam int    ACC_RECIP_W   = $clog2(ACC_RECIP + 1);
    localparam int    QUOT_W        = ACC_PROD_W + ACC_RECIP_W - ACC_SHIFT;

    // Percent divide: magnitudes at or above the limit saturate.
    localparam int    SCALE_W     = MOVE_W + GAIN_W + 1;
    localparam int    PCT_SAT     = (SAT_MAX + 1) * PCT;
    localparam int    PCT_IN_W    = $clog2(PCT_SAT);
    localparam int    PCT_SHIFT   = PCT_IN_W + $clog2(PCT) + 1;
    localparam longint PCT_RECIP  = ((longint'(1) <<< PCT_SHIFT) + PCT - 1) / PCT;
    localparam int    PCT_RECIP_W = $clog2(PCT_RECIP + 1);

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One classified report as it waits for the arithmetic.
    typedef struct packed {
        logic                     scroll;
        logic [BTN_W-1:0]         buttons;
        logic                     must_send;
        logic signed [MOVE_W-1:0] move_x;
        logic signed [MOVE_W-1:0] move_y;
    } gtm_item_t;

    // Gain configuration as seen by the back.
    typedef struct packed {
        logic [GAIN_W-1:0] base;
        logic [GAIN_W-1:0] accel;
        logic [GAIN_W-1:0] ceiling;
    } gtm_gain_t;

    // Absolute value saturated to the speed width.
    function automatic logic [SPEED_W-1:0] abs_sat(input logic signed [MOVE_W-1:0] v);
        logic [MOVE_W:0] mag;
        mag = v[MOVE_W-1] ? ((MOVE_W+1)'(0) - {v[MOVE_W-1], v}) : {1'b0, v};
        return (mag[MOVE_W:SPEED_W] != '0) ? {SPEED_W{1'b1}} : mag[SPEED_W-1:0];
    endfunction

    // Motion divided by eight toward zero, saturated.
    function automatic logic signed [DELTA_W-1:0] wheel_step(
        input logic signed [MOVE_W-1:0] v);
        logic [MOVE_W:0]                mag;
        logic [MOVE_W-WHEEL_SHIFT:0]    q;
        logic [DELTA_W-1:0]             m;
        mag = v[MOVE_W-1] ? ((MOVE_W+1)'(0) - {v[MOVE_W-1], v}) : {1'b0, v};
        q   = mag[MOVE_W:WHEEL_SHIFT];
        m   = (q > (MOVE_W-WHEEL_SHIFT+1)'(SAT_MAX)) ? DELTA_W'(SAT_MAX)
                                                       : DELTA_W'(q);
        return v[MOVE_W-1] ? $signed(DELTA_W'(0) - m) : $signed(m);
    endfunction

    // Scaled motion divided by one hundred toward zero, saturated.
    function automatic logic signed [DELTA_W-1:0] pct_scale(
        input logic signed [SCALE_W-1:0] p);
        logic [SCALE_W-1:0]                 mag;
        logic [PCT_IN_W+PCT_RECIP_W-1:0]    prod;
        logic [DELTA_W-1:0]                 m;
        mag  = p[SCALE_W-1] ? (SCALE_W'(0) - p) : p;
        prod = mag[PCT_IN_W-1:0] * PCT_RECIP_W'(PCT_RECIP);
        if (mag >= SCALE_W'(PCT_SAT)) begin
            m = DELTA_W'(SAT_MAX);
        end else begin
            m = DELTA_W'(prod >> PCT_SHIFT);
        end
        return p[SCALE_W-1] ? $signed(DELTA_W'(0) - m) : $signed(m);
    endfunction

endpackage

// ===== sv/gtm_front.sv =====
module gtm_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            push,
    input  logic [gtm_pkg::GEST_W-1:0]      gesture_a,
    input  logic [gtm_pkg::GEST_W-1:0]      gesture_b,
    input  logic [gtm_pkg::FINGER_W-1:0]    finger_count,
    input  logic signed [gtm_pkg::MOVE_W-1:0] move_x,
    input  logic signed [gtm_pkg::MOVE_W-1:0] move_y,
    output gtm_pkg::gtm_item_t              item
);
    import gtm_pkg::*;

    logic [FINGER_W-1:0] peak_reg;
    logic [FINGER_W-1:0] peak_next;
    logic                dragging_reg;
    logic                dragging_next;
    logic                release_reg;
    logic                release_next;

    logic [FINGER_W-1:0] peak_now;
    logic                fingers_down;
    logic                drag_live;
    logic                drag_ended;
    logic [BTN_W-1:0]    buttons;
    logic                must_send;

    // Touch, drag and tap bookkeeping for the beat on the input.
    always_comb begin
        fingers_down  = (finger_count != '0);
        peak_now      = (finger_count > peak_reg) ? finger_count : peak_reg;
        drag_live     = dragging_reg | gesture_a[GA_HOLD_BIT];
        must_send     = gesture_a[GA_HOLD_BIT] & ~dragging_reg;
        drag_ended    = drag_live & ~fingers_down;
        dragging_next = drag_live & fingers_down;
        buttons       = dragging_next ? BTN_LEFT : BTN_NONE;
        release_next  = 1'b0;
        if (drag_ended) begin
            must_send = 1'b1;
        end
        // A pending release wins over everything; taps count only outside a drag.
        if (release_reg) begin
            buttons   = BTN_NONE;
            must_send = 1'b1;
        end else if (!dragging_next && !drag_ended) begin
            if (gesture_b[GB_TAP2_BIT]) begin
                buttons      = BTN_RIGHT;
                release_next = 1'b1;
                must_send    = 1'b1;
            end else if (gesture_a[GA_TAP_BIT]) begin
                buttons      = (peak_now >= MIDDLE_MIN_FINGERS) ? BTN_MIDDLE : BTN_LEFT;
                release_next = 1'b1;
                must_send    = 1'b1;
            end
        end
        peak_next = fingers_down ? peak_now : '0;
    end

    // Classified item for the queue.
    always_comb begin
        item.scroll    = gesture_b[GB_SCROLL_BIT];
        item.buttons   = buttons;
        item.must_send = must_send;
        item.move_x    = move_x;
        item.move_y    = move_y;
    end

    // State moves only when a beat is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg     <= '0;
            dragging_reg <= 1'b0;
            release_reg  <= 1'b0;
        end else if (push) begin
            peak_reg     <= peak_next;
            dragging_reg <= dragging_next;
            release_reg  <= release_next;
        end
    end

endmodule

// ===== sv/gtm_queue.sv =====
module gtm_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  gtm_pkg::gtm_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output gtm_pkg::gtm_item_t head_item
);
    import gtm_pkg::*;

    gtm_item_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/gtm_back.sv =====
module gtm_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  gtm_pkg::gtm_gain_t                gain,
    input  logic                              head_valid,
    input  gtm_pkg::gtm_item_t                head_item,
    output logic                              pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [gtm_pkg::DELTA_W-1:0] m_delta_x,
    output logic signed [gtm_pkg::DELTA_W-1:0] m_delta_y,
    output logic signed [gtm_pkg::DELTA_W-1:0] m_wheel_v,
    output logic signed [gtm_pkg::DELTA_W-1:0] m_wheel_h,
    output logic [gtm_pkg::BTN_W-1:0]         m_button_mask,
    output logic                              m_send_report
);
    import gtm_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ACCEL = 3'd1;
    localparam logic [2:0] ST_RECIP = 3'd2;
    localparam logic [2:0] ST_CLAMP = 3'd3;
    localparam logic [2:0] ST_SCALE = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]                state_reg;
    logic [2:0]                state_next;
    logic                      out_load;
    logic                      m_valid_reg;

    gtm_item_t                 item_reg;
    logic [SPEED_W-1:0]        speed_reg;
    logic [ACC_PROD_W-1:0]     acc_prod_reg;
    logic [QUOT_W-1:0]         quot_reg;
    logic [GAIN_W-1:0]         gain_reg;
    logic signed [SCALE_W-1:0] scale_x_reg;
    logic signed [SCALE_W-1:0] scale_y_reg;
    logic signed [DELTA_W-1:0] dx_reg;
    logic signed [DELTA_W-1:0] dy_reg;
    logic signed [DELTA_W-1:0] wv_reg;
    logic signed [DELTA_W-1:0] wh_reg;

    logic signed [DELTA_W-1:0] out_dx_reg;
    logic signed [DELTA_W-1:0] out_dy_reg;
    logic signed [DELTA_W-1:0] out_wv_reg;
    logic signed [DELTA_W-1:0] out_wh_reg;
    logic [BTN_W-1:0]          out_btn_reg;
    logic                      out_send_reg;

    logic [SPEED_W-1:0]                 abs_x;
    logic [SPEED_W-1:0]                 abs_y;
    logic [ACC_PROD_W+ACC_RECIP_W-1:0]  recip_prod;
    logic [QUOT_W:0]                    gain_sum;

    assign pop      = (state_reg == ST_IDLE) && head_valid;
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    assign abs_x      = abs_sat(head_item.move_x);
    assign abs_y      = abs_sat(head_item.move_y);
    assign recip_prod = acc_prod_reg * ACC_RECIP_W'(ACC_RECIP);
    assign gain_sum   = (QUOT_W+1)'(gain.base) + (QUOT_W+1)'(quot_reg);

    // Step sequencer: scroll items go straight to the output step.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (head_valid) begin
                    state_next = head_item.scroll ? ST_OUT : ST_ACCEL;
                end
            end
            ST_ACCEL: state_next = ST_RECIP;
            ST_RECIP: state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_SCALE;
            ST_SCALE: state_next = ST_DIV;
            ST_DIV:   state_next = ST_OUT;
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Arithmetic datapath, one step per state.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                item_reg  <= head_item;
                speed_reg <= (abs_x > abs_y) ? abs_x : abs_y;
                dx_reg    <= '0;
                dy_reg    <= '0;
                if (head_item.scroll) begin
                    wv_reg <= wheel_step(head_item.move_y);
                    wh_reg <= wheel_step(head_item.move_x);
                end else begin
                    wv_reg <= '0;
                    wh_reg <= '0;
                end
            end
            ST_ACCEL: begin
                acc_prod_reg <= gain.accel * speed_reg;
            end
            ST_RECIP: begin
                quot_reg <= QUOT_W'(recip_prod >> ACC_SHIFT);
            end
            ST_CLAMP: begin
                gain_reg <= (gain_sum > (QUOT_W+1)'(gain.ceiling)) ? gain.ceiling
                                                                    : GAIN_W'(gain_sum);
            end
            ST_SCALE: begin
                scale_x_reg <= item_reg.move_x * $signed({1'b0, gain_reg});
                scale_y_reg <= item_reg.move_y * $signed({1'b0, gain_reg});
            end
            ST_DIV: begin
                dx_reg <= pct_scale(scale_x_reg);
                dy_reg <= pct_scale(scale_y_reg);
            end
            default: begin
            end
        endcase
    end

    // Output register holds a finished beat while the next item is worked on.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_dx_reg   <= dx_reg;
            out_dy_reg   <= dy_reg;
            out_wv_reg   <= wv_reg;
            out_wh_reg   <= wh_reg;
            out_btn_reg  <= item_reg.buttons;
            out_send_reg <= item_reg.must_send || (dx_reg != '0) || (dy_reg != '0)
                            || (wv_reg != '0) || (wh_reg != '0)
                            || (item_reg.buttons != BTN_NONE);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_delta_x     = out_dx_reg;
    assign m_delta_y     = out_dy_reg;
    assign m_wheel_v     = out_wv_reg;
    assign m_wheel_h     = out_wh_reg;
    assign m_button_mask = out_btn_reg;
    assign m_send_report = out_send_reg;

endmodule

// ===== sv/trackpad_gesture_to_hid_mapper.sv =====
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    gesture_a, gesture_b, finger_count, move_x, move_y
// m_        out        m_valid/m_ready    delta_x/y, wheel_v/h, button_mask, send_report
// cfg_      in         cfg_we             cfg_index, cfg_data (no read-back)
//
// A cursor report passes through the back end in order: the accel multiply, the reciprocal
// divide, the gain clamp, the percent multiply and divide, each in a state of its own.
// A scroll report goes from idle straight to the output step of the back-end sequencer.
// The front takes one beat per cycle while the two-entry queue has room.
// Reset is synchronous and active low; gains return to base 100, accel 0, ceiling 100.
// A stalled output holds its beat while the back end finishes the next report.
module trackpad_gesture_to_hid_mapper (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [gtm_pkg::GEST_W-1:0]          s_gesture_a,
    input  logic [gtm_pkg::GEST_W-1:0]          s_gesture_b,
    input  logic [gtm_pkg::FINGER_W-1:0]        s_finger_count,
    input  logic signed [gtm_pkg::MOVE_W-1:0]   s_move_x,
    input  logic signed [gtm_pkg::MOVE_W-1:0]   s_move_y,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [gtm_pkg::DELTA_W-1:0]  m_delta_x,
    output logic signed [gtm_pkg::DELTA_W-1:0]  m_delta_y,
    output logic signed [gtm_pkg::DELTA_W-1:0]  m_wheel_v,
    output logic signed [gtm_pkg::DELTA_W-1:0]  m_wheel_h,
    output logic [gtm_pkg::BTN_W-1:0]           m_button_mask,
    output logic                                m_send_report,
    input  logic                                cfg_we,
    input  logic [gtm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gtm_pkg::GAIN_W-1:0]          cfg_data
);
    import gtm_pkg::*;

    gtm_gain_t gain_reg;
    gtm_item_t front_item;
    gtm_item_t head_item;
    logic      push;
    logic      pop;
    logic      q_full;
    logic      head_valid;

    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;

    // Gain configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg.base    <= GAIN_BASE_RST;
            gain_reg.accel   <= GAIN_ACCEL_RST;
            gain_reg.ceiling <= GAIN_CEILING_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_GAIN_BASE:    gain_reg.base    <= cfg_data;
                CFG_GAIN_ACCEL:   gain_reg.accel   <= cfg_data;
                CFG_GAIN_CEILING: gain_reg.ceiling <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    gtm_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (push),
        .gesture_a    (s_gesture_a),
        .gesture_b    (s_gesture_b),
        .finger_count (s_finger_count),
        .move_x       (s_move_x),
        .move_y       (s_move_y),
        .item         (front_item)
    );

    gtm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (front_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    gtm_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .gain          (gain_reg),
        .head_valid    (head_valid),
        .head_item     (head_item),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_delta_x     (m_delta_x),
        .m_delta_y     (m_delta_y),
        .m_wheel_v     (m_wheel_v),
        .m_wheel_h     (m_wheel_h),
        .m_button_mask (m_button_mask),
        .m_send_report (m_send_report)
    );

    // A beat without the send flag carries no motion, wheel or button.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_send_report) |-> (m_delta_x == '0 && m_delta_y == '0
            && m_wheel_v == '0 && m_wheel_h == '0 && m_button_mask == BTN_NONE))
        else $error("report without send flag carries data");

    // Wheel and cursor motion never appear in the same beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_wheel_v != '0 || m_wheel_h != '0))
            |-> (m_delta_x == '0 && m_delta_y == '0))
        else $error("wheel and cursor motion in one report");

    // At most one button is pressed in any beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0(m_button_mask))
        else $error("more than one button in a report");

    // Saturation never yields the most negative code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_delta_x != 8'sh80 && m_delta_y != 8'sh80
            && m_wheel_v != 8'sh80 && m_wheel_h != 8'sh80))
        else $error("delta outside the saturated range");

endmodule
